// ===== hdl/sird_pkg.sv =====
// Shared constants, types and helper functions of the radix digit writer.
package sird_pkg;

  // Field and storage widths
  localparam int VALUE_W     = 32;
  localparam int SYMBOL_W    = 8;
  localparam int DIGIT_W     = 4;
  localparam int REG_SYMBOLS = 16;
  localparam int SYM_IDX_W   = 4;
  localparam int MAX_DIGITS  = 32;
  localparam int DIG_IDX_W   = 5;
  localparam int CNT_W       = 6;
  localparam int SIZE_W      = 5;
  localparam int MIN_SYMBOLS = 2;
  localparam int BIT_CNT_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // Characters with a fixed meaning
  localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE = 2'd2;

  // Kind of character loaded into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_MINUS,
    EMIT_DIGIT,
    EMIT_INVALID
  } emit_kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 load;
    logic                 chk;
    logic [SYM_IDX_W-1:0] chk_idx;
    logic                 div_step;
    logic                 store;
    emit_kind_t           emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad;
    logic quot_zero;
    logic cnt_last;
    logic cnt_one;
    logic neg;
    logic out_free;
  } stat_t;

  // Picks alphabet symbol k out of the two alphabet registers.
  function automatic logic [SYMBOL_W-1:0] sym_at(input logic [CFG_DATA_W-1:0] lo,
                                                 input logic [CFG_DATA_W-1:0] hi,
                                                 input logic [SYM_IDX_W-1:0]  k);
    logic [CFG_DATA_W-1:0] w;
    w = k[SYM_IDX_W-1] ? hi : lo;
    return w[k[SYM_IDX_W-2:0]*SYMBOL_W +: SYMBOL_W];
  endfunction

endpackage

// ===== hdl/sird_ifs.sv =====
// Handshake channel interfaces: input values, output characters, configuration writes.
interface sird_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sird_pkg::VALUE_W-1:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface sird_out_if;
  logic                          valid;
  logic                          ready;
  logic [sird_pkg::SYMBOL_W-1:0] symbol;
  logic                          last;
  logic                          invalid_base;
  modport source (output valid, symbol, last, invalid_base, input ready);
  modport sink   (input valid, symbol, last, invalid_base, output ready);
endinterface

interface sird_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sird_pkg::CFG_IDX_W-1:0]  index;
  logic [sird_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/signed_integer_to_radix_digits_unit.sv =====
// Top level of the signed integer to radix digit writer.
//
// Usage: write the alphabet over cfg_bus (index 0: symbols 0 to 7, index 1: symbols
// 8 to 15, index 2: alphabet size, which is the base) while the block is idle; other
// indexes are ignored. Each beat on in_bus carries one signed 32-bit value. The block
// answers on out_bus with one beat per character: a '-' for a negative value, then
// the digits from most significant to least, the final one with last set. An invalid
// alphabet gives a single beat with invalid_base and last set and symbol zero.
// Sequence: an accepted value is loaded, all 16 symbol positions of the alphabet are
// checked one symbol a cycle, a decision step follows, then each digit passes through
// the shift divider (32 one-bit restoring steps and one store), then one output beat
// per cycle while the receiver is ready. in_bus.ready is high only between items.
// A registered output stage holds each beat; when the receiver stalls the block
// waits with the next character. Reset clears the alphabet to zero (invalid) and
// drops any item in progress; the digit buffer is not cleared.
module signed_integer_to_radix_digits_unit #(
  parameter int MAX_SYMBOLS = 16
) (
  input logic        clk,
  input logic        rst_n,
  sird_in_if.sink    in_bus,
  sird_out_if.source out_bus,
  sird_cfg_if.sink   cfg_bus
);
  import sird_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Configuration writes are always taken.
  assign cfg_bus.ready = 1'b1;

  sird_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sird_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_value         (in_bus.value),
    .cfg_we           (cfg_bus.valid && cfg_bus.ready),
    .cfg_index        (cfg_bus.index),
    .cfg_data         (cfg_bus.data),
    .out_ready        (out_bus.ready),
    .out_valid        (out_bus.valid),
    .out_symbol       (out_bus.symbol),
    .out_last         (out_bus.last),
    .out_invalid_base (out_bus.invalid_base)
  );

  // An invalid-alphabet beat ends the item and carries no character.
  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.invalid_base) |-> (out_bus.last && (out_bus.symbol == '0)))
    else $error("invalid-alphabet beat without last or with a symbol");

  // The minus sign is always followed by digits.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.invalid_base && (out_bus.symbol == CH_MINUS)) |->
    !out_bus.last)
    else $error("minus sign marked as final character");

  // Once a value is taken, no further value is taken until it is finished.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("input taken while an item is in progress");

  // Digits are only emitted once the division has run down to a zero quotient.
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == EMIT_DIGIT) |-> stat.quot_zero)
    else $error("digit emitted before the division finished");

endmodule

// ===== hdl/sird_ctrl.sv =====
// Sequencer of the radix digit writer: alphabet check, division steps, character output.
module sird_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sird_pkg::stat_t stat,
  output sird_pkg::cmd_t  cmd
);
  import sird_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_DIVIDE,
    ST_STORE,
    ST_SIGN,
    ST_EMIT,
    ST_EMIT_INV
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SYM_IDX_W-1:0]   idx_r, idx_nxt;
  logic [BIT_CNT_W-1:0]   bit_r, bit_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    bit_nxt     = bit_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.emit    = EMIT_NONE;
    cmd.chk_idx = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.chk = 1'b1;
        idx_nxt = idx_r + SYM_IDX_W'(1);
        if (idx_r == '1) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        bit_nxt   = '0;
        state_nxt = stat.bad ? ST_EMIT_INV : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + BIT_CNT_W'(1);
        if (bit_r == '1) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        bit_nxt   = '0;
        state_nxt = (stat.quot_zero || stat.cnt_last) ? ST_SIGN : ST_DIVIDE;
      end
      ST_SIGN: begin
        if (!stat.neg) begin
          state_nxt = ST_EMIT;
        end else if (stat.out_free) begin
          cmd.emit  = EMIT_MINUS;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_DIGIT;
          if (stat.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_INV: begin
        if (stat.out_free) begin
          cmd.emit  = EMIT_INVALID;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

// ===== hdl/sird_dp.sv =====
// Datapath of the radix digit writer: alphabet registers, shift divider, digit buffer, output register.
module sird_dp #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sird_pkg::cmd_t                      cmd,
  output sird_pkg::stat_t                     stat,
  input  logic signed [sird_pkg::VALUE_W-1:0] in_value,
  input  logic                                cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [sird_pkg::SYMBOL_W-1:0]       out_symbol,
  output logic                                out_last,
  output logic                                out_invalid_base
);
  import sird_pkg::*;

  logic [CFG_DATA_W-1:0] alpha_lo_r;
  logic [CFG_DATA_W-1:0] alpha_hi_r;
  logic [SIZE_W-1:0]     size_r;

  logic [VALUE_W-1:0]    quot_r;
  logic [DIGIT_W-1:0]    rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  neg_r;
  logic                  bad_r;
  logic [DIGIT_W-1:0]    digit_store_r [MAX_DIGITS];

  logic                  out_valid_r;
  logic [SYMBOL_W-1:0]   sym_r;
  logic                  last_r;
  logic                  inv_r;

  logic                  size_ok;
  logic                  chk_bad;
  logic                  dup;
  logic [SYMBOL_W-1:0]   sym_i;
  logic [VALUE_W-1:0]    raw;
  logic [VALUE_W-1:0]    mag;
  logic [DIGIT_W:0]      trial;
  logic                  ge;
  logic [DIGIT_W:0]      trial_sub;
  logic [CNT_W-1:0]      cnt_dec;
  logic [DIGIT_W-1:0]    rd_digit;
  logic                  out_free;

  // Alphabet size rule
  assign size_ok = (size_r >= SIZE_W'(MIN_SYMBOLS)) && (int'(size_r) <= MAX_SYMBOLS) &&
                   (size_r <= SIZE_W'(REG_SYMBOLS));

  // One symbol a cycle is checked against the sign characters and all later symbols.
  always_comb begin
    sym_i = sym_at(alpha_lo_r, alpha_hi_r, cmd.chk_idx);
    dup   = 1'b0;
    for (int j = 0; j < REG_SYMBOLS; j++) begin
      if ((j > int'(cmd.chk_idx)) && (j < int'(size_r)) &&
          (sym_at(alpha_lo_r, alpha_hi_r, SYM_IDX_W'(j)) == sym_i)) begin
        dup = 1'b1;
      end
    end
    chk_bad = ({1'b0, cmd.chk_idx} < size_r) &&
              ((sym_i == CH_PLUS) || (sym_i == CH_MINUS) || dup);
  end

  // Magnitude of the input, exact for the most negative value
  assign raw = VALUE_W'(in_value);
  assign mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

  // One restoring division step: remainder and quotient shift left together.
  assign trial     = {rem_r, quot_r[VALUE_W-1]};
  assign ge        = trial >= size_r;
  assign trial_sub = trial - size_r;

  // Buffered digit read in reverse order
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign rd_digit = digit_store_r[cnt_dec[DIG_IDX_W-1:0]];

  assign out_free = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
      size_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA_LO:   alpha_lo_r <= cfg_data;
        CFG_ALPHA_HI:   alpha_hi_r <= cfg_data;
        CFG_ALPHA_SIZE: size_r     <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control flags and digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      bad_r <= 1'b0;
      neg_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
        bad_r <= !size_ok;
        neg_r <= raw[VALUE_W-1];
      end else if (cmd.chk && chk_bad) begin
        bad_r <= 1'b1;
      end
      if (cmd.store) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.emit == EMIT_DIGIT) begin
        cnt_r <= cnt_dec;
      end
    end
  end

  // Divider registers and digit buffer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r <= mag;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[VALUE_W-2:0], ge};
      rem_r  <= ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end else if (cmd.store) begin
      rem_r <= '0;
    end
    if (cmd.store) begin
      digit_store_r[cnt_r[DIG_IDX_W-1:0]] <= rem_r;
    end
  end

  // Output register: holds one beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_MINUS: begin
        sym_r  <= CH_MINUS;
        last_r <= 1'b0;
        inv_r  <= 1'b0;
      end
      EMIT_DIGIT: begin
        sym_r  <= sym_at(alpha_lo_r, alpha_hi_r, rd_digit);
        last_r <= (cnt_r == CNT_W'(1));
        inv_r  <= 1'b0;
      end
      EMIT_INVALID: begin
        sym_r  <= '0;
        last_r <= 1'b1;
        inv_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = sym_r;
  assign out_last         = last_r;
  assign out_invalid_base = inv_r;

  // Status to the controller
  assign stat.bad       = bad_r;
  assign stat.quot_zero = (quot_r == '0);
  assign stat.cnt_last  = (cnt_r == CNT_W'(MAX_DIGITS - 1));
  assign stat.cnt_one   = (cnt_r == CNT_W'(1));
  assign stat.neg       = neg_r;
  assign stat.out_free  = out_free;

endmodule
